>>> hw/rtl/grj_pkg.sv
package grj_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int EXP_DEPTH_DEF = 256;
	localparam int WORD_W        = 32;
	localparam int NUM_REGS      = 6;
	localparam int REG_IDX_W     = 3;

	localparam longint Q_MAX = 64'sd2147483647;
	localparam longint Q_MIN = -64'sd2147483648;

	typedef logic signed [WORD_W-1:0] q_t;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_PEAK_AMPLITUDE  = 3'd0,
		REG_CENTER_POSITION = 3'd1,
		REG_WIDTH_SIGMA     = 3'd2,
		REG_DIR_AMPLITUDE   = 3'd3,
		REG_DIR_CENTER      = 3'd4,
		REG_DIR_WIDTH       = 3'd5
	} reg_idx_t;

	typedef enum logic [2:0] {
		CST_IDLE,
		CST_LOAD_R,
		CST_DIV_R,
		CST_LOAD_G,
		CST_DIV_G
	} cfg_st_t;

	typedef struct packed {
		q_t               a;
		q_t               b;
		q_t               c;
		logic [WORD_W-1:0] abs_c;
		logic             c_zero;
		q_t               r;
		q_t               g0;
		q_t               vab;
		q_t               vac;
		q_t               vbb;
		q_t               vbc;
		q_t               vcc;
		logic             busy;
	} cfg_t;

	typedef struct packed {
		logic [WORD_W-1:0] rem;
		logic              qbit;
	} div_step_t;

	function automatic q_t sat32(longint v);
		if (v > Q_MAX) return q_t'(Q_MAX[WORD_W-1:0]);
		if (v < Q_MIN) return q_t'(Q_MIN[WORD_W-1:0]);
		return q_t'(v[WORD_W-1:0]);
	endfunction

	function automatic q_t qneg(q_t x);
		return sat32(-longint'(x));
	endfunction

	// Product scaled back by the fraction bits, rounded toward zero.
	function automatic q_t qmul(q_t x, q_t y, int frac);
		longint p;
		p = longint'(x) * longint'(y);
		if (p < 0) p = p + ((longint'(1) << frac) - 1);
		p = p >>> frac;
		return sat32(p);
	endfunction

	function automatic logic [WORD_W-1:0] abs32(q_t x);
		return x[WORD_W-1] ? WORD_W'(-x) : WORD_W'(x);
	endfunction

	// Signed, saturated value of a quotient magnitude.
	function automatic q_t q_from_div(logic [WORD_W-1:0] q, logic ovf, logic neg);
		longint mag;
		mag = ovf ? (longint'(1) << (WORD_W + 1)) : longint'(q);
		return sat32(neg ? -mag : mag);
	endfunction

	function automatic div_step_t div_step(logic [WORD_W-1:0] rem, logic b,
			logic [WORD_W-1:0] den);
		logic [WORD_W:0] r2;
		div_step_t st;
		r2 = {rem, b};
		if (r2 >= {1'b0, den}) begin
			st.rem  = WORD_W'(r2 - {1'b0, den});
			st.qbit = 1'b1;
		end else begin
			st.rem  = r2[WORD_W-1:0];
			st.qbit = 1'b0;
		end
		return st;
	endfunction

endpackage

>>> hw/rtl/gaussian_residual_jacobian_unit.sv
// Throughput: one word per cycle while results are taken and no register write is
// being worked in; three 32-step restoring dividers (z, and the two derivative terms
// over c) set the depth, one quotient bit per step.
// A register write holds s_tready low while a/c and a/c/c are re-derived.
// Reset (arst_n low) empties the pipeline and restores the register reset values.
module gaussian_residual_jacobian_unit #(
	parameter int FRAC_BITS       = grj_pkg::FRAC_BITS_DEF,
	parameter int EXP_TABLE_DEPTH = grj_pkg::EXP_DEPTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [63:0]                  s_tdata,   // sample_position, sample_value
	input  logic                         s_tlast,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	// residual, jac_amplitude, jac_center, jac_width, second_directional
	output logic [159:0]                 m_tdata,
	output logic                         m_tlast,
	output logic [0:0]                   m_tuser,   // width_error
	input  logic                         cfg_we,
	input  logic [grj_pkg::REG_IDX_W-1:0] cfg_index,
	input  logic [grj_pkg::WORD_W-1:0]    cfg_data
);
	import grj_pkg::*;

	localparam int     NUM_W = WORD_W + 1 + FRAC_BITS;
	localparam int     IDX_W = $clog2(EXP_TABLE_DEPTH);
	localparam longint ONE_L = longint'(1) << FRAC_BITS;
	localparam int     SA_W  = 4 * WORD_W;
	localparam int     SB_W  = 3 * WORD_W + 1;

	cfg_t cfg;
	logic en;

	// input side
	q_t                t_in, y_in;
	logic signed [32:0] diff;
	logic [32:0]       dmag;
	logic [NUM_W-1:0]  z_num;

	logic              zv, zovf, zneg;
	logic [WORD_W-1:0] zq;
	logic [32:0]       zside;
	logic [63:0]       zq64, idx_full;

	logic              v_s1, inr_s1, last_s1;
	q_t                z_s1, y_s1;
	logic [IDX_W-1:0]  idx_s1;

	logic              v_s2, inr_s2, last_s2;
	q_t                z_s2, y_s2, e2;
	logic [FRAC_BITS:0] e_s2;

	logic v_s3, last_s3;
	q_t   zz_s3, ez_s3, ae_s3, g_s3, ja_s3, z_s3, y_s3, e_s3;

	logic v_s4, last_s4;
	q_t   ezz_s4, res_s4, jb_s4, gz_s4, gzz_s4, dbb_s4, t2_s4, t3_s4, ez_s4, ja_s4;

	logic v_s5, last_s5;
	q_t   jc_s5, dbc_s5, dcc_s5, f3_s5, ez_s5, ezz_s5, res_s5, ja_s5, jb_s5;

	logic v_s6, last_s6;
	q_t   f4_s6, f5_s6, ez_s6, ezz_s6, res_s6, ja_s6, jb_s6, jc_s6, f3_s6;

	logic              va, vb, qa_ovf, qb_ovf, qa_neg, qb_neg;
	logic [WORD_W-1:0] qa, qb;
	logic [SA_W-1:0]   side_a;
	logic [SB_W-1:0]   side_b;
	q_t                dab, dac;

	logic v_s7, last_s7;
	q_t   f1_s7, f2_s7, f3_s7, f4_s7, f5_s7, res_s7, ja_s7, jb_s7, jc_s7;

	logic         out_valid_q, out_last_q, out_err_q;
	logic [159:0] out_data_q;
	longint       acc;
	q_t           fvv;

	grj_cfg #(.FRAC_BITS(FRAC_BITS)) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// The whole pipeline moves together; it stops only while a result waits.
	assign en       = !out_valid_q || m_tready;
	assign s_tready = en && !cfg.busy;

	assign t_in  = q_t'(s_tdata[31:0]);
	assign y_in  = q_t'(s_tdata[63:32]);
	assign diff  = {t_in[WORD_W-1], t_in} - {cfg.b[WORD_W-1], cfg.b};
	assign dmag  = diff[32] ? 33'(-diff) : 33'(diff);
	assign z_num = {dmag, {FRAC_BITS{1'b0}}};

	grj_div_pipe #(.NUM_W(NUM_W), .SIDE_W(33)) u_zdiv (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (s_tvalid && !cfg.busy),
		.num       (z_num),
		.den       (cfg.abs_c),
		.neg_in    (diff[32] ^ cfg.c[WORD_W-1]),
		.side_in   ({y_in, s_tlast}),
		.out_valid (zv),
		.quot      (zq),
		.ovf       (zovf),
		.neg       (zneg),
		.side_out  (zside)
	);

	assign zq64     = {32'd0, zq};
	assign idx_full = (zq64 * 64'(EXP_TABLE_DEPTH)) >> (FRAC_BITS + 3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			v_s1 <= zv;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= va && vb;
			out_valid_q <= v_s7;
		end
	end

	grj_exp_rom #(.FRAC_BITS(FRAC_BITS), .EXP_TABLE_DEPTH(EXP_TABLE_DEPTH)) u_rom (
		.clk  (clk),
		.en   (en),
		.idx  (idx_s1),
		.e_s2 (e_s2)
	);

	// The table only covers |z| below eight; beyond that e is zero.
	assign e2 = inr_s2 ? q_t'({{(WORD_W-1-FRAC_BITS){1'b0}}, e_s2}) : '0;

	always_ff @(posedge clk) begin
		if (en) begin
			z_s1    <= q_from_div(zq, zovf, zneg);
			inr_s1  <= !zovf && (zq64 < (64'd8 << FRAC_BITS));
			idx_s1  <= idx_full[IDX_W-1:0];
			y_s1    <= q_t'(zside[32:1]);
			last_s1 <= zside[0];

			z_s2    <= z_s1;
			inr_s2  <= inr_s1;
			y_s2    <= y_s1;
			last_s2 <= last_s1;

			zz_s3   <= qmul(z_s2, z_s2, FRAC_BITS);
			ez_s3   <= qmul(e2, z_s2, FRAC_BITS);
			ae_s3   <= qmul(cfg.a, e2, FRAC_BITS);
			g_s3    <= qmul(cfg.g0, e2, FRAC_BITS);
			ja_s3   <= -e2;
			z_s3    <= z_s2;
			y_s3    <= y_s2;
			e_s3    <= e2;
			last_s3 <= last_s2;

			ezz_s4  <= qmul(e_s3, zz_s3, FRAC_BITS);
			res_s4  <= sat32(longint'(y_s3) - longint'(ae_s3));
			jb_s4   <= qneg(qmul(cfg.r, ez_s3, FRAC_BITS));
			gz_s4   <= qmul(g_s3, z_s3, FRAC_BITS);
			gzz_s4  <= qmul(g_s3, zz_s3, FRAC_BITS);
			dbb_s4  <= qmul(g_s3, sat32(ONE_L - longint'(zz_s3)), FRAC_BITS);
			t2_s4   <= sat32(2 * ONE_L - longint'(zz_s3));
			t3_s4   <= sat32(3 * ONE_L - longint'(zz_s3));
			ez_s4   <= ez_s3;
			ja_s4   <= ja_s3;
			last_s4 <= last_s3;

			jc_s5   <= qneg(qmul(cfg.r, ezz_s4, FRAC_BITS));
			dbc_s5  <= qmul(gz_s4, t2_s4, FRAC_BITS);
			dcc_s5  <= qmul(gzz_s4, t3_s4, FRAC_BITS);
			f3_s5   <= qmul(cfg.vbb, dbb_s4, FRAC_BITS);
			ez_s5   <= ez_s4;
			ezz_s5  <= ezz_s4;
			res_s5  <= res_s4;
			ja_s5   <= ja_s4;
			jb_s5   <= jb_s4;
			last_s5 <= last_s4;

			f4_s6   <= sat32(2 * longint'(qmul(cfg.vbc, dbc_s5, FRAC_BITS)));
			f5_s6   <= qmul(cfg.vcc, dcc_s5, FRAC_BITS);
			ez_s6   <= ez_s5;
			ezz_s6  <= ezz_s5;
			res_s6  <= res_s5;
			ja_s6   <= ja_s5;
			jb_s6   <= jb_s5;
			jc_s6   <= jc_s5;
			f3_s6   <= f3_s5;
			last_s6 <= last_s5;
		end
	end

	grj_div_pipe #(.NUM_W(NUM_W), .SIDE_W(SA_W)) u_ezdiv (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s6),
		.num       ({1'b0, abs32(ez_s6), {FRAC_BITS{1'b0}}}),
		.den       (cfg.abs_c),
		.neg_in    (ez_s6[WORD_W-1] ^ cfg.c[WORD_W-1]),
		.side_in   ({res_s6, ja_s6, jb_s6, jc_s6}),
		.out_valid (va),
		.quot      (qa),
		.ovf       (qa_ovf),
		.neg       (qa_neg),
		.side_out  (side_a)
	);

	grj_div_pipe #(.NUM_W(NUM_W), .SIDE_W(SB_W)) u_ezzdiv (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s6),
		.num       ({1'b0, abs32(ezz_s6), {FRAC_BITS{1'b0}}}),
		.den       (cfg.abs_c),
		.neg_in    (ezz_s6[WORD_W-1] ^ cfg.c[WORD_W-1]),
		.side_in   ({f3_s6, f4_s6, f5_s6, last_s6}),
		.out_valid (vb),
		.quot      (qb),
		.ovf       (qb_ovf),
		.neg       (qb_neg),
		.side_out  (side_b)
	);

	assign dab = qneg(q_from_div(qa, qa_ovf, qa_neg));
	assign dac = qneg(q_from_div(qb, qb_ovf, qb_neg));

	always_ff @(posedge clk) begin
		if (en) begin
			f1_s7   <= sat32(2 * longint'(qmul(cfg.vab, dab, FRAC_BITS)));
			f2_s7   <= sat32(2 * longint'(qmul(cfg.vac, dac, FRAC_BITS)));
			res_s7  <= q_t'(side_a[4*WORD_W-1:3*WORD_W]);
			ja_s7   <= q_t'(side_a[3*WORD_W-1:2*WORD_W]);
			jb_s7   <= q_t'(side_a[2*WORD_W-1:WORD_W]);
			jc_s7   <= q_t'(side_a[WORD_W-1:0]);
			f3_s7   <= q_t'(side_b[3*WORD_W:2*WORD_W+1]);
			f4_s7   <= q_t'(side_b[2*WORD_W:WORD_W+1]);
			f5_s7   <= q_t'(side_b[WORD_W:1]);
			last_s7 <= side_b[0];
		end
	end

	assign acc = longint'(f1_s7) + longint'(f2_s7) + longint'(f3_s7)
		+ longint'(f4_s7) + longint'(f5_s7);
	assign fvv = sat32(acc);

	// A zero width clears every numeric field of the word.
	always_ff @(posedge clk) begin
		if (en) begin
			out_data_q <= cfg.c_zero ? '0 : {fvv, jc_s7, jb_s7, ja_s7, res_s7};
			out_last_q <= last_s7;
			out_err_q  <= cfg.c_zero;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tlast  = out_last_q;
	assign m_tuser  = out_err_q;

endmodule

>>> hw/rtl/grj_div_pipe.sv
module grj_div_pipe #(
	parameter int NUM_W  = 49,
	parameter int SIDE_W = 1
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic                      in_valid,
	input  logic [NUM_W-1:0]          num,
	input  logic [grj_pkg::WORD_W-1:0] den,
	input  logic                      neg_in,
	input  logic [SIDE_W-1:0]         side_in,
	output logic                      out_valid,
	output logic [grj_pkg::WORD_W-1:0] quot,
	output logic                      ovf,
	output logic                      neg,
	output logic [SIDE_W-1:0]         side_out
);
	import grj_pkg::*;

	localparam int HI_W  = NUM_W - WORD_W;
	localparam int STEPS = WORD_W;

	logic [WORD_W-1:0] hi_ext;
	logic              ovf_in;

	logic              v_s    [0:STEPS];
	logic [WORD_W-1:0] rem_s  [0:STEPS];
	logic [WORD_W-1:0] lo_s   [0:STEPS];
	logic [WORD_W-1:0] q_s    [0:STEPS];
	logic              ovf_s  [0:STEPS];
	logic              neg_s  [0:STEPS];
	logic [SIDE_W-1:0] side_s [0:STEPS];

	// A quotient that needs more than a word shows in the top part alone.
	assign hi_ext = {{(WORD_W-HI_W){1'b0}}, num[NUM_W-1:WORD_W]};
	assign ovf_in = hi_ext >= den;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0]  <= ovf_in ? '0 : hi_ext;
			lo_s[0]   <= num[WORD_W-1:0];
			q_s[0]    <= '0;
			ovf_s[0]  <= ovf_in;
			neg_s[0]  <= neg_in;
			side_s[0] <= side_in;
		end
	end

	for (genvar k = 0; k < STEPS; k++) begin : g_step
		div_step_t st;

		assign st = div_step(rem_s[k], lo_s[k][WORD_W-1], den);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (en) begin
				v_s[k+1] <= v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1]  <= st.rem;
				lo_s[k+1]   <= lo_s[k] << 1;
				q_s[k+1]    <= {q_s[k][WORD_W-2:0], st.qbit};
				ovf_s[k+1]  <= ovf_s[k];
				neg_s[k+1]  <= neg_s[k];
				side_s[k+1] <= side_s[k];
			end
		end
	end

	assign out_valid = v_s[STEPS];
	assign quot      = q_s[STEPS];
	assign ovf       = ovf_s[STEPS];
	assign neg       = neg_s[STEPS];
	assign side_out  = side_s[STEPS];

endmodule

>>> hw/rtl/grj_exp_rom.sv
module grj_exp_rom #(
	parameter int FRAC_BITS       = 16,
	parameter int EXP_TABLE_DEPTH = 256
) (
	input  logic                               clk,
	input  logic                               en,
	input  logic [$clog2(EXP_TABLE_DEPTH)-1:0] idx,
	output logic [FRAC_BITS:0]                 e_s2
);
	localparam int TAYLOR_TERMS  = 16;
	localparam int SQUARINGS     = 6;
	localparam longint unsigned Den =
		longint'(EXP_TABLE_DEPTH) * longint'(EXP_TABLE_DEPTH);

	typedef logic [FRAC_BITS:0] ent_t;
	typedef ent_t rom_t [EXP_TABLE_DEPTH];

	// Entry i holds exp(-w), w = (8*i/depth)^2/2, from a scaled-down Taylor
	// series that is then squared back up.
	function automatic rom_t build_rom();
		rom_t tbl;
		longint unsigned w, s, term, v, Nt, ii;
		longint sum;
		for (int i = 0; i < EXP_TABLE_DEPTH; i++) begin
			ii   = longint'(i);
			w    = ((64'd32 * ii * ii) << 31) / Den;
			s    = w >> SQUARINGS;
			term = 64'd1 << 31;
			sum  = longint'(64'd1 << 31);
			for (Nt = 1; Nt <= TAYLOR_TERMS; Nt++) begin
				term = ((term * s) >> 31) / Nt;
				if (Nt[0]) sum = sum - longint'(term);
				else sum = sum + longint'(term);
			end
			if (sum < 0) sum = 0;
			v = longint'(sum);
			for (int n = 0; n < SQUARINGS; n++) v = (v * v) >> 31;
			tbl[i] = ent_t'(v >> (31 - FRAC_BITS));
		end
		return tbl;
	endfunction

	localparam rom_t EXP_ROM = build_rom();

	always_ff @(posedge clk) begin
		if (en) begin
			e_s2 <= EXP_ROM[idx];
		end
	end

endmodule

>>> hw/rtl/grj_cfg.sv
module grj_cfg #(
	parameter int FRAC_BITS = grj_pkg::FRAC_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [grj_pkg::REG_IDX_W-1:0] cfg_index,
	input  logic [grj_pkg::WORD_W-1:0]    cfg_data,
	output grj_pkg::cfg_t                cfg
);
	import grj_pkg::*;

	localparam q_t ONE = q_t'(longint'(1) << FRAC_BITS);
	localparam int NUM_W = WORD_W + FRAC_BITS;

	q_t a_q, b_q, c_q, va_q, vb_q, vc_q;
	q_t vab_q, vac_q, vbb_q, vbc_q, vcc_q;
	q_t r_q, g0_q;

	cfg_st_t state_q, state_d;

	logic [WORD_W-1:0] rem_q, lo_q, q_q, abs_c;
	logic [4:0]        cnt_q;
	logic              ovf_q, neg_q, c_zero, done, ovf_ld, loading;
	q_t                src, quot;
	logic [NUM_W-1:0]  num;
	logic [WORD_W-1:0] hi_ext, q_nx;
	div_step_t         st;

	assign abs_c   = abs32(c_q);
	assign c_zero  = c_q == '0;
	assign src     = (state_q == CST_LOAD_G) ? r_q : a_q;
	assign num     = {abs32(src), {FRAC_BITS{1'b0}}};
	assign hi_ext  = {{(WORD_W-FRAC_BITS){1'b0}}, num[NUM_W-1:WORD_W]};
	assign ovf_ld  = hi_ext >= abs_c;
	assign st      = div_step(rem_q, lo_q[WORD_W-1], abs_c);
	assign q_nx    = {q_q[WORD_W-2:0], st.qbit};
	assign quot    = c_zero ? '0 : q_from_div(q_nx, ovf_q, neg_q);
	assign done    = cnt_q == 5'd31;
	assign loading = (state_q == CST_LOAD_R) || (state_q == CST_LOAD_G);

	// After any write, a/c and then (a/c)/c are worked out one bit a cycle.
	always_comb begin
		state_d = state_q;
		case (state_q)
			CST_IDLE:   state_d = CST_IDLE;
			CST_LOAD_R: state_d = CST_DIV_R;
			CST_DIV_R:  if (done) state_d = CST_LOAD_G;
			CST_LOAD_G: state_d = CST_DIV_G;
			CST_DIV_G:  if (done) state_d = CST_IDLE;
			default:    state_d = CST_IDLE;
		endcase
		if (cfg_we) state_d = CST_LOAD_R;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_q   <= ONE;
			b_q   <= '0;
			c_q   <= ONE;
			va_q  <= '0;
			vb_q  <= '0;
			vc_q  <= '0;
			vab_q <= '0;
			vac_q <= '0;
			vbb_q <= '0;
			vbc_q <= '0;
			vcc_q <= '0;
			r_q   <= ONE;
			g0_q  <= ONE;
			cnt_q <= '0;
		end else begin
			if (cfg_we) begin
				case (reg_idx_t'(cfg_index))
					REG_PEAK_AMPLITUDE:  a_q  <= q_t'(cfg_data);
					REG_CENTER_POSITION: b_q  <= q_t'(cfg_data);
					REG_WIDTH_SIGMA:     c_q  <= q_t'(cfg_data);
					REG_DIR_AMPLITUDE:   va_q <= q_t'(cfg_data);
					REG_DIR_CENTER:      vb_q <= q_t'(cfg_data);
					REG_DIR_WIDTH:       vc_q <= q_t'(cfg_data);
					default:             ;
				endcase
			end
			vab_q <= qmul(va_q, vb_q, FRAC_BITS);
			vac_q <= qmul(va_q, vc_q, FRAC_BITS);
			vbb_q <= qmul(vb_q, vb_q, FRAC_BITS);
			vbc_q <= qmul(vb_q, vc_q, FRAC_BITS);
			vcc_q <= qmul(vc_q, vc_q, FRAC_BITS);
			if (loading) cnt_q <= '0;
			else cnt_q <= cnt_q + 5'd1;
			if (state_q == CST_DIV_R && done) r_q <= quot;
			if (state_q == CST_DIV_G && done) g0_q <= quot;
		end
	end

	always_ff @(posedge clk) begin
		if (loading) begin
			rem_q <= ovf_ld ? '0 : hi_ext;
			lo_q  <= num[WORD_W-1:0];
			q_q   <= '0;
			ovf_q <= ovf_ld;
			neg_q <= src[WORD_W-1] ^ c_q[WORD_W-1];
		end else begin
			rem_q <= st.rem;
			lo_q  <= lo_q << 1;
			q_q   <= q_nx;
		end
	end

	always_comb begin
		cfg.a      = a_q;
		cfg.b      = b_q;
		cfg.c      = c_q;
		cfg.abs_c  = abs_c;
		cfg.c_zero = c_zero;
		cfg.r      = r_q;
		cfg.g0     = g0_q;
		cfg.vab    = vab_q;
		cfg.vac    = vac_q;
		cfg.vbb    = vbb_q;
		cfg.vbc    = vbc_q;
		cfg.vcc    = vcc_q;
		cfg.busy   = state_q != CST_IDLE;
	end

endmodule

>>> tb/gaussian_residual_jacobian_unit_test.sv
module gaussian_residual_jacobian_unit_test;
	timeunit 1ns;
	timeprecision 1ps;

	import grj_pkg::*;

	localparam longint ONE_Q      = 64'sd65536;
	localparam int     TAB_DEPTH  = 256;
	localparam int     LATENCY    = 74;
	localparam int     SETTLE     = LATENCY + 80;
	localparam int     STALL_LIM  = 20000;

	typedef struct packed {
		logic signed [31:0] residual;
		logic signed [31:0] jac_a;
		logic signed [31:0] jac_b;
		logic signed [31:0] jac_c;
		logic signed [31:0] second_dir;
		logic               last;
		logic               width_err;
	} fit_word_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [63:0]  s_tdata = '0;
	logic         s_tlast = 1'b0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [159:0] m_tdata;
	logic         m_tlast;
	logic [0:0]   m_tuser;
	logic         cfg_we = 1'b0;
	logic [REG_IDX_W-1:0] cfg_index = '0;
	logic [WORD_W-1:0]    cfg_data = '0;

	fit_word_t expected_words[$];
	longint    model_regs[NUM_REGS];
	longint    exp_lut[TAB_DEPTH];
	int        send_idle_pct = 0;
	int        recv_stall_pct = 0;
	int        mismatches = 0;
	int        quiet_cycles = 0;

	gaussian_residual_jacobian_unit u_top (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.m_tuser(m_tuser),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #2 clk = ~clk;

	function automatic longint clip32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint fx_mul(longint x, longint y);
		return clip32((x * y) / ONE_Q);
	endfunction

	function automatic longint fx_div(longint x, longint y);
		if (y == 0) return 0;
		return clip32((x * ONE_Q) / y);
	endfunction

	// Table entry: exp(-w/64) by a truncated series, then squared six times in Q.31.
	function automatic longint exp_entry_value(int idx);
		longint unsigned w, s, term, v, ui;
		longint sum;
		ui = longint'(idx);
		w = ((64'd32 * ui * ui) << 31) / (TAB_DEPTH * TAB_DEPTH);
		s = w >> 6;
		term = 64'd1 << 31;
		sum = 64'sd1 << 31;
		for (int n = 1; n <= 16; n++) begin
			term = ((term * s) >> 31) / n;
			if (n % 2 == 1) sum -= longint'(term);
			else sum += longint'(term);
		end
		if (sum < 0) sum = 0;
		v = longint'(sum);
		for (int n = 0; n < 6; n++)
			v = (v * v) >> 31;
		return longint'(v >> 15);
	endfunction

	function automatic fit_word_t predict_fit(logic signed [31:0] t_in,
			logic signed [31:0] y_in, logic last_in);
		fit_word_t r;
		longint a, b, c, va, vb, vc, t, y;
		longint zfull, mag, e, z, zz, ez, ezz, ac, g, acc;
		longint dab, dac, dbb, dbc, dcc;
		a = model_regs[REG_PEAK_AMPLITUDE];
		b = model_regs[REG_CENTER_POSITION];
		c = model_regs[REG_WIDTH_SIGMA];
		va = model_regs[REG_DIR_AMPLITUDE];
		vb = model_regs[REG_DIR_CENTER];
		vc = model_regs[REG_DIR_WIDTH];
		t = t_in;
		y = y_in;
		r = '{default: '0};
		r.last = last_in;
		if (c == 0) begin
			r.width_err = 1'b1;
			return r;
		end
		zfull = ((t - b) * ONE_Q) / c;
		mag = zfull < 0 ? -zfull : zfull;
		e = 0;
		if (mag < (64'sd8 << 16))
			e = exp_lut[(mag * TAB_DEPTH) >>> 19];
		z = clip32(zfull);
		zz = fx_mul(z, z);
		ez = fx_mul(e, z);
		ezz = fx_mul(e, zz);
		ac = fx_div(a, c);
		r.residual = 32'(clip32(y - fx_mul(a, e)));
		r.jac_a = 32'(clip32(-e));
		r.jac_b = 32'(clip32(-fx_mul(ac, ez)));
		r.jac_c = 32'(clip32(-fx_mul(ac, ezz)));
		g = fx_mul(fx_div(ac, c), e);
		dab = clip32(-fx_div(ez, c));
		dac = clip32(-fx_div(ezz, c));
		dbb = fx_mul(g, clip32(ONE_Q - zz));
		dbc = fx_mul(fx_mul(g, z), clip32(2 * ONE_Q - zz));
		dcc = fx_mul(fx_mul(g, zz), clip32(3 * ONE_Q - zz));
		acc = clip32(2 * fx_mul(fx_mul(va, vb), dab));
		acc += clip32(2 * fx_mul(fx_mul(va, vc), dac));
		acc += fx_mul(fx_mul(vb, vb), dbb);
		acc += clip32(2 * fx_mul(fx_mul(vb, vc), dbc));
		acc += fx_mul(fx_mul(vc, vc), dcc);
		r.second_dir = 32'(clip32(acc));
		return r;
	endfunction

	// Result checker, receiver stalls and the stall watchdog.
	always @(posedge clk) begin
		fit_word_t want;
		fit_word_t got;
		m_tready <= ($urandom_range(99) >= recv_stall_pct);
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > STALL_LIM) begin
			$display("RESULT: ERROR");
			$finish;
		end
		if (m_tvalid && m_tready) begin
			got.residual = m_tdata[31:0];
			got.jac_a = m_tdata[63:32];
			got.jac_b = m_tdata[95:64];
			got.jac_c = m_tdata[127:96];
			got.second_dir = m_tdata[159:128];
			got.last = m_tlast;
			got.width_err = m_tuser[0];
			if (expected_words.size() == 0) begin
				mismatches <= mismatches + 1;
				if (mismatches < 10)
					$display("unexpected word %h", m_tdata);
			end else begin
				want = expected_words.pop_front();
				if (got !== want) begin
					mismatches <= mismatches + 1;
					if (mismatches < 10)
						$display({"mismatch: expected %0d %0d %0d %0d %0d l%b e%b, ",
							"got %0d %0d %0d %0d %0d l%b e%b"},
							want.residual, want.jac_a, want.jac_b, want.jac_c,
							want.second_dir, want.last, want.width_err,
							got.residual, got.jac_a, got.jac_b, got.jac_c,
							got.second_dir, got.last, got.width_err);
				end
			end
		end
	end

	task automatic send_sample(logic signed [31:0] t, logic signed [31:0] y, logic last);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {y, t};
		s_tlast <= last;
		expected_words.push_back(predict_fit(t, y, last));
		do @(posedge clk); while (!s_tready);
	endtask

	// Stops sending and waits until every word is back and the pipe is empty.
	task automatic drain_pipe();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (expected_words.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(int idx, logic [31:0] value);
		cfg_we <= 1'b1;
		cfg_index <= REG_IDX_W'(idx);
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx < NUM_REGS)
			model_regs[idx] = longint'(signed'(value));
		@(posedge clk);
	endtask

	function automatic logic [31:0] rand_word();
		case ($urandom_range(5))
			0: return 32'h7fffffff;
			1: return 32'h80000000;
			2: return $urandom_range(32'h3ffff) - 32'h1ffff;
			default: return $urandom;
		endcase
	endfunction

	// Samples mostly placed within ten widths of the centre, so the table is exercised.
	task automatic send_random_sample();
		longint t;
		logic [31:0] y;
		if ($urandom_range(99) < 70)
			t = clip32(model_regs[REG_CENTER_POSITION]
				+ (model_regs[REG_WIDTH_SIGMA] * (int'($urandom_range(320)) - 160)) / 16);
		else
			t = longint'(signed'(rand_word()));
		y = $urandom_range(1) ? rand_word() : $urandom_range(32'h7ffff) - 32'h3ffff;
		send_sample(t[31:0], y, $urandom_range(7) == 0);
	endtask

	task automatic test_reset_extremes();
		send_sample(0, 0, 1'b0);
		send_sample(32'sh0007_ffff, 32'sh7fffffff, 1'b1);
		send_sample(32'sh0008_0000, 32'sh80000000, 1'b0);
		send_sample(-32'sh0008_0000, 32'sh0001_0000, 1'b1);
		send_sample(-32'sh0007_ffff, -1, 1'b0);
		send_sample(32'sh7fffffff, 32'shffffffff, 1'b0);
		send_sample(32'sh80000000, 32'sh55555555, 1'b1);
		send_sample(32'sh0000_8000, 32'shaaaaaaaa, 1'b0);
		drain_pipe();
	endtask

	task automatic test_direction_and_saturation();
		write_reg(REG_PEAK_AMPLITUDE, 32'h7fffffff);
		write_reg(REG_CENTER_POSITION, 32'h80000000);
		write_reg(REG_WIDTH_SIGMA, 32'h0000_0001);
		write_reg(REG_DIR_AMPLITUDE, 32'h7fffffff);
		write_reg(REG_DIR_CENTER, 32'h80000000);
		write_reg(REG_DIR_WIDTH, 32'h0001_0000);
		send_sample(32'h80000000, 0, 1'b0);
		send_sample(32'h80000001, 32'h80000000, 1'b1);
		drain_pipe();
		write_reg(REG_WIDTH_SIGMA, 32'h0002_0000);
		write_reg(REG_CENTER_POSITION, 0);
		write_reg(REG_PEAK_AMPLITUDE, 32'h0003_0000);
		send_sample(32'h0001_0000, 0, 1'b0);
		send_sample(-32'sh0003_0000, 32'h7fffffff, 1'b0);
		send_sample(32'h0000_4000, 32'h0000_1000, 1'b1);
		drain_pipe();
	endtask

	task automatic test_zero_width();
		write_reg(REG_WIDTH_SIGMA, 0);
		send_sample(0, 32'h7fffffff, 1'b1);
		send_sample(32'h1234_5678, -5, 1'b0);
		drain_pipe();
		// Indexes past the register list must leave every register alone.
		write_reg(NUM_REGS, 32'h0001_0000);
		write_reg(NUM_REGS + 1, 32'hffffffff);
		send_sample(0, 1, 1'b1);
		drain_pipe();
		write_reg(REG_WIDTH_SIGMA, 32'hffff_0000);
		send_sample(32'h0000_8000, 1, 1'b0);
		drain_pipe();
	endtask

	task automatic load_random_setting(int k);
		logic [31:0] c;
		if (k == 0) begin
			write_reg(REG_PEAK_AMPLITUDE, 32'h0001_0000);
			write_reg(REG_CENTER_POSITION, 0);
			write_reg(REG_WIDTH_SIGMA, 32'h0001_0000);
			write_reg(REG_DIR_AMPLITUDE, 32'h0000_8000);
			write_reg(REG_DIR_CENTER, 32'hffff_0000);
			write_reg(REG_DIR_WIDTH, 32'h0002_0000);
			return;
		end
		c = $urandom_range(32'h3ffff) + 32'h100;
		if ($urandom_range(3) == 0) c = $urandom;
		if (c == 0) c = 1;
		if ($urandom_range(1)) c = -c;
		write_reg(REG_PEAK_AMPLITUDE, rand_word());
		write_reg(REG_CENTER_POSITION, rand_word());
		write_reg(REG_WIDTH_SIGMA, c);
		write_reg(REG_DIR_AMPLITUDE, rand_word());
		write_reg(REG_DIR_CENTER, rand_word());
		write_reg(REG_DIR_WIDTH, rand_word());
	endtask

	task automatic test_random_samples();
		int idle_modes[4][2] = '{'{0, 0}, '{77, 0}, '{0, 77}, '{7, 7}};
		for (int p = 0; p < 4; p++) begin
			send_idle_pct = idle_modes[p][0];
			recv_stall_pct = idle_modes[p][1];
			for (int k = 0; k < 7; k++) begin
				load_random_setting(k);
				repeat (25) send_random_sample();
				drain_pipe();
			end
		end
		send_idle_pct = 0;
		recv_stall_pct = 0;
	endtask

	initial begin
		for (int i = 0; i < TAB_DEPTH; i++)
			exp_lut[i] = exp_entry_value(i);
		model_regs = '{ONE_Q, 0, ONE_Q, 0, 0, 0};
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_extremes();
		test_direction_and_saturation();
		test_zero_width();
		test_random_samples();
		if (mismatches == 0 && expected_words.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
